// ===== hw/rtl/udprr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// udprr_pkg
// Shared types, codes and the checksum helper of the round-robin UDP header
// rewrite block.
// ----------------------------------------------------------------------------
package udprr_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int MAC_W       = 48;
  localparam int ADDR_W      = 32;
  localparam int PORT_W      = 16;
  localparam int SLOT_W      = 6;
  localparam int COUNT_W     = 7;
  localparam int ENTRY_W     = MAC_W + ADDR_W + PORT_W;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  localparam logic OP_TABLE_WRITE = 1'b0;
  localparam logic OP_HEADER      = 1'b1;

  localparam logic CFG_LISTEN_PORT   = 1'b0;
  localparam logic CFG_BACKEND_COUNT = 1'b1;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
  } backend_t;

  // RFC 1624 eqn. 3 over the two halves of the destination address
  function automatic logic [15:0] checksum_update(input logic [15:0] hc,
                                                  input logic [31:0] old_addr,
                                                  input logic [31:0] new_addr);
    logic [18:0] s;
    logic [16:0] f1;
    logic [15:0] f2;
    s  = {3'b0, ~hc} + {3'b0, ~old_addr[31:16]} + {3'b0, ~old_addr[15:0]}
       + {3'b0, new_addr[31:16]} + {3'b0, new_addr[15:0]};
    f1 = {1'b0, s[15:0]} + {14'b0, s[18:16]};
    f2 = f1[15:0] + {15'b0, f1[16]};
    return ~f2;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/udprr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// udprr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module udprr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/udp_round_robin_header_rewrite.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// udp_round_robin_header_rewrite
// Backend table plus round-robin selection and IPv4/UDP header rewrite.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_stall is low and returns exactly one
// result per item after acceptance: the registered read of the backend table
// RAM comes first, then the output register holding the rewritten header and
// the incremental checksum. Table writes go into the RAM at acceptance and
// are visible to a header accepted in the next cycle. The table holds
// min(MAX_BACKENDS, 64) slots and is undefined until written.
module udp_round_robin_header_rewrite #(
  parameter int MAX_BACKENDS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic [5:0]  in_entry_index,
  input  wire logic [47:0] in_entry_mac,
  input  wire logic [31:0] in_entry_address,
  input  wire logic [15:0] in_entry_port,
  input  wire logic [15:0] in_ether_type,
  input  wire logic [7:0]  in_ip_protocol,
  input  wire logic [15:0] in_udp_dst_port,
  input  wire logic [31:0] in_src_address,
  input  wire logic [31:0] in_dst_address,
  input  wire logic [15:0] in_header_checksum,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_forward,
  output logic [5:0]       out_backend_index,
  output logic [47:0]      out_new_dst_mac,
  output logic [31:0]      out_new_dst_address,
  output logic [15:0]      out_new_dst_port,
  output logic [15:0]      out_new_header_checksum,
  output logic             out_udp_checksum
);

  localparam int DEPTH  = (MAX_BACKENDS < udprr_pkg::TABLE_DEPTH) ?
                          MAX_BACKENDS : udprr_pkg::TABLE_DEPTH;
  localparam int RAM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [udprr_pkg::COUNT_W-1:0] LIMIT = udprr_pkg::COUNT_W'(DEPTH);

  // configuration
  logic [15:0]                     listen_port_r;
  logic [udprr_pkg::COUNT_W-1:0]   backend_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_port_r   <= '0;
      backend_count_r <= udprr_pkg::COUNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        udprr_pkg::CFG_LISTEN_PORT:   listen_port_r   <= cfg_data;
        udprr_pkg::CFG_BACKEND_COUNT: backend_count_r <= cfg_data[udprr_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [udprr_pkg::COUNT_W-1:0] count;
  always_comb begin
    if (backend_count_r == '0) begin
      count = udprr_pkg::COUNT_W'(1);
    end else if (backend_count_r > LIMIT) begin
      count = LIMIT;
    end else begin
      count = backend_count_r;
    end
  end

  // handshake
  logic s1_v_r, s2_v_r;
  logic s1_adv, in_acc;

  assign s1_adv   = !s2_v_r || !out_stall;
  assign in_stall = s1_v_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // decision and round robin
  logic                          pass;
  logic [udprr_pkg::SLOT_W-1:0]  next_r, next_nxt, sel;
  logic [udprr_pkg::COUNT_W-1:0] sel_inc;

  assign pass = (in_operation == udprr_pkg::OP_HEADER)
             && (in_ether_type == udprr_pkg::ETHERTYPE_IPV4)
             && (in_ip_protocol == udprr_pkg::PROTO_UDP)
             && (in_udp_dst_port == listen_port_r);

  always_comb begin
    sel      = ({1'b0, next_r} >= count) ? '0 : next_r;
    sel_inc  = {1'b0, sel} + udprr_pkg::COUNT_W'(1);
    next_nxt = next_r;
    if (in_acc && pass) begin
      next_nxt = (sel_inc >= count) ? '0 : sel_inc[udprr_pkg::SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_r <= '0;
    end else begin
      next_r <= next_nxt;
    end
  end

  // backend table
  logic               tbl_we;
  udprr_pkg::backend_t tbl_wdata, tbl_rdata;

  assign tbl_we    = in_acc && (in_operation == udprr_pkg::OP_TABLE_WRITE)
                  && ({1'b0, in_entry_index} < LIMIT);
  assign tbl_wdata = '{mac: in_entry_mac, addr: in_entry_address, port: in_entry_port};

  udprr_ram #(
    .WIDTH (udprr_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (in_entry_index[RAM_AW-1:0]),
    .wdata (tbl_wdata),
    .re    (in_acc && pass),
    .raddr (sel[RAM_AW-1:0]),
    .rdata (tbl_rdata)
  );

  // stage 1: waiting on table read
  logic                         s1_fwd_r;
  logic [udprr_pkg::SLOT_W-1:0] s1_sel_r;
  logic [31:0]                  s1_dst_r;
  logic [15:0]                  s1_hc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_fwd_r <= pass;
      s1_sel_r <= sel;
      s1_dst_r <= in_dst_address;
      s1_hc_r  <= in_header_checksum;
    end
  end

  // stage 2: output register
  logic                         fwd_r;
  logic [udprr_pkg::SLOT_W-1:0] idx_r;
  logic [47:0]                  mac_r;
  logic [31:0]                  addr_r;
  logic [15:0]                  port_r;
  logic [15:0]                  csum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s1_adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_v_r) begin
      fwd_r <= s1_fwd_r;
      if (s1_fwd_r) begin
        idx_r  <= s1_sel_r;
        mac_r  <= tbl_rdata.mac;
        addr_r <= tbl_rdata.addr;
        port_r <= tbl_rdata.port;
        csum_r <= udprr_pkg::checksum_update(s1_hc_r, s1_dst_r, tbl_rdata.addr);
      end else begin
        idx_r  <= '0;
        mac_r  <= '0;
        addr_r <= '0;
        port_r <= '0;
        csum_r <= '0;
      end
    end
  end

  assign out_valid               = s2_v_r;
  assign out_forward             = fwd_r;
  assign out_backend_index       = idx_r;
  assign out_new_dst_mac         = mac_r;
  assign out_new_dst_address     = addr_r;
  assign out_new_dst_port        = port_r;
  assign out_new_header_checksum = csum_r;
  assign out_udp_checksum        = 1'b0;

  // source address is carried for completeness; it does not steer anything
  logic unused_src;
  assign unused_src = ^in_src_address;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the round-robin UDP header rewrite block item by item: backend table
// writes, the IPv4/UDP/listen-port filter, round-robin backend choice and the
// incremental header checksum, over several register settings and handshake
// idling patterns.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic        op;
    logic [5:0]  idx;
    logic [47:0] mac;
    logic [31:0] eaddr;
    logic [15:0] eport;
    logic [15:0] ether;
    logic [7:0]  proto;
    logic [15:0] dport;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] hc;
  } item_t;

  typedef struct packed {
    logic        forward;
    logic [5:0]  slot;
    logic [47:0] mac;
    logic [31:0] addr;
    logic [15:0] dport;
    logic [15:0] csum;
    logic        udp_csum;
  } rewrite_t;

  class rewrite_scoreboard;
    logic [15:0] listen_port_q;
    logic [6:0]  count_q;
    logic [47:0] mac_tab [udprr_pkg::TABLE_DEPTH];
    logic [31:0] addr_tab [udprr_pkg::TABLE_DEPTH];
    logic [15:0] port_tab [udprr_pkg::TABLE_DEPTH];
    bit          loaded [udprr_pkg::TABLE_DEPTH];
    int unsigned rr_ptr;
    rewrite_t    expected_q [$];
    int          errors;

    function new();
      listen_port_q = '0;
      count_q = 7'd1;
      rr_ptr = 0;
      errors = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    function int unsigned active_backends();
      int unsigned n;
      n = 32'(count_q);
      if (n == 0) n = 1;
      if (n > udprr_pkg::TABLE_DEPTH) n = udprr_pkg::TABLE_DEPTH;
      return n;
    endfunction

    function int unsigned upcoming_slot();
      return (rr_ptr >= active_backends()) ? 0 : rr_ptr;
    endfunction

    function bit would_forward(item_t it);
      return it.op == udprr_pkg::OP_HEADER && it.ether == udprr_pkg::ETHERTYPE_IPV4 &&
             it.proto == udprr_pkg::PROTO_UDP && it.dport == listen_port_q;
    endfunction

    // one's complement update for the destination address change
    function logic [15:0] patch_checksum(logic [15:0] hc, logic [31:0] old_a,
                                         logic [31:0] new_a);
      logic [31:0] acc;
      acc = {16'h0, ~hc} + {16'h0, ~old_a[31:16]} + {16'h0, ~old_a[15:0]}
          + {16'h0, new_a[31:16]} + {16'h0, new_a[15:0]};
      acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
      acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
      return ~acc[15:0];
    endfunction

    function void note_item(item_t it);
      rewrite_t    r;
      int unsigned s;
      r = '0;
      if (it.op == udprr_pkg::OP_TABLE_WRITE) begin
        mac_tab[it.idx]  = it.mac;
        addr_tab[it.idx] = it.eaddr;
        port_tab[it.idx] = it.eport;
        loaded[it.idx]   = 1'b1;
      end else if (would_forward(it)) begin
        s = upcoming_slot();
        rr_ptr = (s + 1 >= active_backends()) ? 0 : s + 1;
        r.forward = 1'b1;
        r.slot    = s[5:0];
        r.mac     = mac_tab[s];
        r.addr    = addr_tab[s];
        r.dport   = port_tab[s];
        r.csum    = patch_checksum(it.hc, it.dst, addr_tab[s]);
      end
      expected_q.push_back(r);
    endfunction

    function void compare(string name, logic [47:0] want, logic [47:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(rewrite_t got);
      rewrite_t want;
      if (expected_q.size() == 0) begin
        $error("result with no item pending");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare("forward", 48'(want.forward), 48'(got.forward));
      compare("backend_index", 48'(want.slot), 48'(got.slot));
      compare("new_dst_mac", want.mac, got.mac);
      compare("new_dst_address", 48'(want.addr), 48'(got.addr));
      compare("new_dst_port", 48'(want.dport), 48'(got.dport));
      compare("new_header_checksum", 48'(want.csum), 48'(got.csum));
      compare("udp_checksum", 48'(want.udp_csum), 48'(got.udp_csum));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        in_operation;
  logic [5:0]  in_entry_index;
  logic [47:0] in_entry_mac;
  logic [31:0] in_entry_address;
  logic [15:0] in_entry_port;
  logic [15:0] in_ether_type;
  logic [7:0]  in_ip_protocol;
  logic [15:0] in_udp_dst_port;
  logic [31:0] in_src_address;
  logic [31:0] in_dst_address;
  logic [15:0] in_header_checksum;
  logic        out_valid;
  logic        out_stall;
  logic        out_forward;
  logic [5:0]  out_backend_index;
  logic [47:0] out_new_dst_mac;
  logic [31:0] out_new_dst_address;
  logic [15:0] out_new_dst_port;
  logic [15:0] out_new_header_checksum;
  logic        out_udp_checksum;

  rewrite_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_req;

  udp_round_robin_header_rewrite dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_operation           (in_operation),
    .in_entry_index         (in_entry_index),
    .in_entry_mac           (in_entry_mac),
    .in_entry_address       (in_entry_address),
    .in_entry_port          (in_entry_port),
    .in_ether_type          (in_ether_type),
    .in_ip_protocol         (in_ip_protocol),
    .in_udp_dst_port        (in_udp_dst_port),
    .in_src_address         (in_src_address),
    .in_dst_address         (in_dst_address),
    .in_header_checksum     (in_header_checksum),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_forward            (out_forward),
    .out_backend_index      (out_backend_index),
    .out_new_dst_mac        (out_new_dst_mac),
    .out_new_dst_address    (out_new_dst_address),
    .out_new_dst_port       (out_new_dst_port),
    .out_new_header_checksum(out_new_header_checksum),
    .out_udp_checksum       (out_udp_checksum)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // mostly random, now and then all zeros or all ones
  function automatic logic [47:0] spread(int unsigned w);
    logic [47:0] m;
    logic [47:0] v;
    m = (48'h1 << w) - 48'h1;
    case ($urandom_range(15))
      0: v = '0;
      1: v = '1;
      default: v = 48'({$urandom, $urandom});
    endcase
    return v & m;
  endfunction

  function automatic item_t table_entry(logic [5:0] idx, logic [47:0] mac,
                                        logic [31:0] addr, logic [15:0] port);
    item_t        it;
    logic [255:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    it.op    = udprr_pkg::OP_TABLE_WRITE;
    it.idx   = idx;
    it.mac   = mac;
    it.eaddr = addr;
    it.eport = port;
    return it;
  endfunction

  function automatic item_t header_item(logic [15:0] ether, logic [7:0] proto,
                                        logic [15:0] dport, logic [31:0] dst,
                                        logic [15:0] hc);
    item_t        it;
    logic [255:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    it.op    = udprr_pkg::OP_HEADER;
    it.ether = ether;
    it.proto = proto;
    it.dport = dport;
    it.dst   = dst;
    it.hc    = hc;
    return it;
  endfunction

  task automatic send(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_operation       <= it.op;
    in_entry_index     <= it.idx;
    in_entry_mac       <= it.mac;
    in_entry_address   <= it.eaddr;
    in_entry_port      <= it.eport;
    in_ether_type      <= it.ether;
    in_ip_protocol     <= it.proto;
    in_udp_dst_port    <= it.dport;
    in_src_address     <= it.src;
    in_dst_address     <= it.dst;
    in_header_checksum <= it.hc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic send_random();
    item_t       it;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) begin
      it = table_entry(6'($urandom_range(63)), spread(48), 32'(spread(32)),
                       16'(spread(16)));
    end else begin
      it = header_item(udprr_pkg::ETHERTYPE_IPV4, udprr_pkg::PROTO_UDP, sb.listen_port_q,
                       32'(spread(32)), 16'(spread(16)));
      it.src = 32'(spread(32));
      if (r >= 85) begin
        case ($urandom_range(3))
          0: it.ether = 16'(spread(16));
          1: it.proto = 8'(spread(8));
          2: it.dport = 16'(spread(16));
          default: begin
            it.ether = 16'($urandom);
            it.proto = 8'($urandom);
            it.dport = 16'($urandom);
          end
        endcase
      end
      // never select a slot that holds nothing yet
      if (sb.would_forward(it) && !sb.loaded[sb.upcoming_slot()])
        it = table_entry(6'(sb.upcoming_slot()), spread(48), 32'(spread(32)),
                         16'(spread(16)));
    end
    send(it);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == udprr_pkg::CFG_LISTEN_PORT) sb.listen_port_q = d;
    else sb.count_q = d[6:0];
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // result side: check, then choose next cycle's stall
  initial begin
    int unsigned hold_left;
    bit          stall;
    rewrite_t    got;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.forward  = out_forward;
        got.slot     = out_backend_index;
        got.mac      = out_new_dst_mac;
        got.addr     = out_new_dst_address;
        got.dport    = out_new_dst_port;
        got.csum     = out_new_header_checksum;
        got.udp_csum = out_udp_checksum;
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 80;
        stall     = 1'b1;
      end else begin
        stall = $urandom_range(99) < recv_idle_pct;
      end
      out_stall <= stall;
    end
  end

  initial begin
    int unsigned counts [7];
    logic [8:0]  upper;
    logic [15:0] listen;
    counts             = '{64, 127, 3, 1, 37, 2, 64};
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = udprr_pkg::CFG_LISTEN_PORT;
    cfg_data           = '0;
    in_valid           = 1'b0;
    in_operation       = udprr_pkg::OP_TABLE_WRITE;
    in_entry_index     = '0;
    in_entry_mac       = '0;
    in_entry_address   = '0;
    in_entry_port      = '0;
    in_ether_type      = '0;
    in_ip_protocol     = '0;
    in_udp_dst_port    = '0;
    in_src_address     = '0;
    in_dst_address     = '0;
    in_header_checksum = '0;
    hold_req           = 1'b0;
    send_idle_pct      = 6;
    recv_idle_pct      = 52;
    sb = new;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: listen port 0, one backend
    send(table_entry(6'd0, '1, '1, '1));
    send(header_item(udprr_pkg::ETHERTYPE_IPV4, udprr_pkg::PROTO_UDP, 16'h0000, 32'h0,
                     16'h0));
    send(header_item(udprr_pkg::ETHERTYPE_IPV4, udprr_pkg::PROTO_UDP, 16'h0000, '1, '1));
    send(header_item(16'h86DD, udprr_pkg::PROTO_UDP, 16'h0000, $urandom, 16'($urandom)));
    send(header_item(udprr_pkg::ETHERTYPE_IPV4, 8'd6, 16'h0000, $urandom, 16'($urandom)));
    send(header_item(udprr_pkg::ETHERTYPE_IPV4, udprr_pkg::PROTO_UDP, 16'h0001, $urandom,
                     16'($urandom)));
    send(header_item(16'hFFFF, 8'hFF, 16'hFFFF, $urandom, 16'($urandom)));
    send(table_entry(6'd63, '0, '0, '0));
    send(table_entry(6'd0, '0, '0, '0));
    send(header_item(udprr_pkg::ETHERTYPE_IPV4, udprr_pkg::PROTO_UDP, 16'h0000, '1, 16'h0));
    send(table_entry(6'd0, spread(48), 32'(spread(32)), 16'(spread(16))));
    send(header_item(udprr_pkg::ETHERTYPE_IPV4, udprr_pkg::PROTO_UDP, 16'h0000, $urandom,
                     16'($urandom)));
    settle();

    // top listen port, zero count acts as one backend, upper data bits ignored
    write_reg(udprr_pkg::CFG_LISTEN_PORT, 16'hFFFF);
    write_reg(udprr_pkg::CFG_BACKEND_COUNT, 16'hFF80);
    send(header_item(udprr_pkg::ETHERTYPE_IPV4, udprr_pkg::PROTO_UDP, 16'hFFFF, $urandom,
                     16'($urandom)));
    send(header_item(udprr_pkg::ETHERTYPE_IPV4, udprr_pkg::PROTO_UDP, 16'hFFFE, $urandom,
                     16'($urandom)));
    send(header_item(udprr_pkg::ETHERTYPE_IPV4, udprr_pkg::PROTO_UDP, 16'h0000, $urandom,
                     16'($urandom)));
    send(table_entry(6'd63, '1, '1, '1));
    send(header_item(udprr_pkg::ETHERTYPE_IPV4, udprr_pkg::PROTO_UDP, 16'hFFFF, $urandom,
                     16'($urandom)));
    settle();

    for (int i = 0; i < udprr_pkg::TABLE_DEPTH; i++)
      send(table_entry(6'(i), spread(48), 32'(spread(32)), 16'(spread(16))));
    settle();

    for (int s = 0; s < 7; s++) begin
      if (s >= 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (s >= 3) begin
        send_idle_pct = 52;
        recv_idle_pct = 6;
      end
      listen = (s == 1) ? 16'h0000 : 16'($urandom_range(65535));
      upper  = 9'($urandom_range(511));
      write_reg(udprr_pkg::CFG_LISTEN_PORT, listen);
      write_reg(udprr_pkg::CFG_BACKEND_COUNT, {upper, counts[s][6:0]});
      if (s >= 5) hold_req = 1'b1;
      repeat (100) send_random();
      settle();
    end

    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/udprr_pkg.sv
hw/rtl/udprr_ram.sv
hw/rtl/udp_round_robin_header_rewrite.sv
tb/testbench.sv
